// ----- hdl/keypad_code_fifo_top_assert.svh -----
// Assertion macros for the keypad code FIFO.
// Used by keypad_code_fifo_top; depends on nothing else.
`ifndef KEYPAD_CODE_FIFO_TOP_ASSERT_SVH
`define KEYPAD_CODE_FIFO_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KCF_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("keypad_code_fifo assertion failed");
`define KCF_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("keypad_code_fifo assertion failed");
`else
`define KCF_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define KCF_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- hdl/kcf_pkg.sv -----
// Shared types, codes and the scan decode table of the keypad code FIFO.
// No dependencies; imported by kcf_ctrl, kcf_dp and keypad_code_fifo_top.
package kcf_pkg;

	typedef enum logic [1:0] {
		OP_SCAN    = 2'd0,
		OP_IMITATE = 2'd1,
		OP_GET     = 2'd2,
		OP_PROBE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// Which generated word a scan event writes.
	typedef enum logic [1:0] {
		W_PRESS       = 2'd0,
		W_RELEASE     = 2'd1,
		W_SYS_PRESS   = 2'd2,
		W_SYS_RELEASE = 2'd3
	} word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_PUSH,
		S_READ,
		S_DONE
	} fsm_t;

	localparam logic [4:0]  KEY_F        = 5'd15;
	localparam logic [4:0]  KEY_D        = 5'd13;
	localparam logic [4:0]  KEY_RIGHT    = 5'd22;
	localparam logic [4:0]  KEY_SYSTEM   = 5'd24;
	localparam logic [4:0]  KEY_NONE     = 5'd31;
	localparam logic [31:0] WORD_BASE    = 32'h100;
	localparam logic [31:0] WORD_RELEASE = 32'h80;

	typedef struct packed {
		logic    capture;
		logic    shift;
		logic    push;
		logic    push_imm;
		word_t   word_sel;
		logic    rd_en;
		logic    take_data;
		logic    pop;
		logic    set_status;
		status_t status_val;
		logic    load_out;
	} kcf_cmd_t;

	typedef struct packed {
		op_t  op;
		logic enabled;
		logic key_none;
		logic sys_next;
		logic room2;
		logic room4;
		logic not_full;
		logic not_empty;
	} kcf_sts_t;

	// Scan byte to key number; unknown bytes give KEY_NONE.
	function automatic logic [4:0] decode_scan(logic [7:0] scan);
		logic [4:0] key;
		case (scan)
			8'h07: key = 5'd0;
			8'h06: key = 5'd1;
			8'h05: key = 5'd2;
			8'h04: key = 5'd3;
			8'h0B: key = 5'd4;
			8'h0A: key = 5'd5;
			8'h09: key = 5'd6;
			8'h08: key = 5'd7;
			8'h13: key = 5'd8;
			8'h12: key = 5'd9;
			8'h11: key = 5'd10;
			8'h10: key = 5'd11;
			8'h23: key = 5'd12;
			8'h22: key = 5'd13;
			8'h21: key = 5'd14;
			8'h20: key = 5'd15;
			8'h43: key = 5'd16;
			8'h80: key = 5'd17;
			8'h41: key = 5'd18;
			8'h40: key = 5'd19;
			8'h83: key = 5'd20;
			8'h82: key = 5'd21;
			8'h81: key = 5'd22;
			8'h42: key = 5'd23;
			default: key = KEY_NONE;
		endcase
		return key;
	endfunction

endpackage

// ----- hdl/kcf_in_if.sv -----
// Input channel of the keypad code FIFO: valid, ready and the operation item.
// No dependencies.
interface kcf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  scan_code;
	logic [31:0] imitated_code;

	modport source (output valid, output op, output scan_code, output imitated_code,
		input ready);
	modport sink (input valid, input op, input scan_code, input imitated_code,
		output ready);
endinterface

// ----- hdl/kcf_out_if.sv -----
// Result channel of the keypad code FIFO: valid, ready and the result item.
// No dependencies.
interface kcf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] code;
	logic [1:0]  status;
	logic [5:0]  fill_count;

	modport source (output valid, output code, output status, output fill_count,
		input ready);
	modport sink (input valid, input code, input status, input fill_count,
		output ready);
endinterface

// ----- hdl/kcf_ctrl.sv -----
// Controller state machine of the keypad code FIFO.
// Depends on kcf_pkg; drives the datapath through kcf_cmd_t.
module kcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  kcf_pkg::kcf_sts_t sts,
	output kcf_pkg::kcf_cmd_t cmd
);
	import kcf_pkg::*;

	fsm_t  state_q, state_d;
	word_t word_q, word_d;
	logic  sys_q, sys_d;
	logic  out_valid_q, out_valid_d;
	logic  last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			word_q      <= W_PRESS;
			sys_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			word_q      <= word_d;
			sys_q       <= sys_d;
			out_valid_q <= out_valid_d;
		end
	end

	// The system key words follow the pair of the key itself.
	assign last_word = (word_q == W_SYS_RELEASE) || (word_q == W_RELEASE && !sys_q);

	always_comb begin
		state_d     = state_q;
		word_d      = word_q;
		sys_d       = sys_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				case (sts.op)
					OP_SCAN: begin
						if (!sts.enabled || sts.key_none) begin
							cmd.set_status = 1'b1;
							cmd.status_val = ST_IGNORED;
						end else begin
							cmd.shift = 1'b1;
							if (sts.sys_next ? sts.room4 : sts.room2) begin
								sys_d   = sts.sys_next;
								word_d  = W_PRESS;
								state_d = S_PUSH;
							end else begin
								cmd.set_status = 1'b1;
								cmd.status_val = ST_FULL;
							end
						end
					end
					OP_IMITATE: begin
						if (sts.not_full) begin
							cmd.push     = 1'b1;
							cmd.push_imm = 1'b1;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status_val = ST_FULL;
						end
					end
					default: begin
						if (sts.not_empty) begin
							cmd.rd_en = 1'b1;
							state_d   = S_READ;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status_val = ST_EMPTY;
						end
					end
				endcase
			end
			S_PUSH: begin
				cmd.push     = 1'b1;
				cmd.word_sel = word_q;
				word_d       = word_t'(word_q + 2'd1);
				if (last_word) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.take_data = 1'b1;
				cmd.pop       = (sts.op == OP_GET);
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/kcf_dp.sv -----
// Datapath of the keypad code FIFO: word store, pointers, key history, result registers.
// Depends on kcf_pkg; commanded by kcf_ctrl.
module kcf_dp #(
	parameter int FIFO_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic [1:0]        in_op,
	input  logic [7:0]        in_scan_code,
	input  logic [31:0]       in_imitated_code,
	input  kcf_pkg::kcf_cmd_t cmd,
	output kcf_pkg::kcf_sts_t sts,
	output logic [31:0]       code,
	output logic [1:0]        status,
	output logic [5:0]        fill_count
);
	import kcf_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
	localparam logic [CW-1:0] CNT_LIM2 = CW'(FIFO_DEPTH - 2);
	localparam logic [CW-1:0] CNT_LIM4 = CW'(FIFO_DEPTH - 4);

	logic [31:0]   mem [FIFO_DEPTH];
	logic [31:0]   rd_data_q;
	logic [PW-1:0] rd_ptr_q, wr_ptr_q;
	logic [CW-1:0] count_q;
	logic [4:0]    hist_q [3];
	logic          enabled_q;
	op_t           op_q;
	logic [4:0]    key_q;
	logic [31:0]   imm_q;
	logic [31:0]   res_code_q;
	status_t       res_status_q;
	logic [31:0]   out_code_q;
	status_t       out_status_q;
	logic [5:0]    out_fill_q;
	logic [31:0]   wr_word;

	always_comb begin
		case (cmd.word_sel)
			W_PRESS:     wr_word = WORD_BASE | 32'(key_q);
			W_RELEASE:   wr_word = WORD_BASE | WORD_RELEASE | 32'(key_q);
			W_SYS_PRESS: wr_word = WORD_BASE | 32'(KEY_SYSTEM);
			default:     wr_word = WORD_BASE | WORD_RELEASE | 32'(KEY_SYSTEM);
		endcase
		if (cmd.push_imm) begin
			wr_word = imm_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_ptr_q] <= wr_word;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			hist_q[0] <= KEY_NONE;
			hist_q[1] <= KEY_NONE;
			hist_q[2] <= KEY_NONE;
			enabled_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
			end
			if (cmd.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end else if (cmd.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (cmd.shift) begin
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= op_t'(in_op);
			key_q        <= decode_scan(in_scan_code);
			imm_q        <= in_imitated_code;
			res_code_q   <= '0;
			res_status_q <= ST_OK;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status_val;
		end
		if (cmd.take_data) begin
			res_code_q <= rd_data_q;
		end
		if (cmd.load_out) begin
			out_code_q   <= res_code_q;
			out_status_q <= res_status_q;
			out_fill_q   <= 6'(count_q);
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.enabled   = enabled_q;
		sts.key_none  = (key_q == KEY_NONE);
		// Pattern F, right, D, judged on the history as it will be after the shift.
		sts.sys_next  = (hist_q[1] == KEY_F) && (hist_q[0] == KEY_RIGHT) && (key_q == KEY_D);
		sts.room2     = (count_q <= CNT_LIM2);
		sts.room4     = (count_q <= CNT_LIM4);
		sts.not_full  = (count_q != CNT_FULL);
		sts.not_empty = (count_q != '0);
	end

	assign code       = out_code_q;
	assign status     = out_status_q;
	assign fill_count = out_fill_q;

endmodule

// ----- hdl/keypad_code_fifo_top.sv -----
// Top level of the keypad code FIFO: controller, datapath and channel wiring.
// Depends on kcf_pkg, kcf_in_if, kcf_out_if, kcf_ctrl, kcf_dp and the assertion header.
//
// Usage: each item on in_ch carries an operation: a keypad scan event, an
// imitated push of a 32-bit word, a pop (get) or a peek (probe) of the oldest
// word. Every item yields exactly one result item on out_ch with the popped or
// peeked word (zero otherwise), a status code and the word count afterwards.
// The one configuration bit, enabled, is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle, which the block itself does
// not enforce. Scan events are ignored while it is zero. One item is processed
// at a time: an imitate or any refused operation is decided and its result
// loaded; a get or probe first does a registered store read; a scan event first
// writes its two or four words through the single store write port, one per
// cycle. The result is valid the cycle after the load and in_ch is ready again
// at the same time, so a new item is taken only once the last one's result is
// loaded. A finished result sits in the output register while the next item is
// taken; if the receiver stalls, that item's result waits in the datapath's
// staging registers, with in_ch not ready, until the output register frees.
// Reset empties the FIFO, fills the key history with the no-key mark and clears
// enabled; the store contents are not cleared.
`include "keypad_code_fifo_top_assert.svh"
module keypad_code_fifo_top #(
	parameter int FIFO_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	kcf_in_if.sink     in_ch,
	kcf_out_if.source  out_ch
);
	import kcf_pkg::*;

	kcf_cmd_t cmd;
	kcf_sts_t sts;

	kcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kcf_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_op            (in_ch.op),
		.in_scan_code     (in_ch.scan_code),
		.in_imitated_code (in_ch.imitated_code),
		.cmd              (cmd),
		.sts              (sts),
		.code             (out_ch.code),
		.status           (out_ch.status),
		.fill_count       (out_ch.fill_count)
	);

	// Only one item is in work at a time.
	`KCF_ASSERT_NEXT(a_one_item, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	// The controller never writes into a full store nor pops an empty one.
	`KCF_ASSERT_IMPLIES(a_push_room, clk, arst_n, cmd.push, sts.not_full)
	`KCF_ASSERT_IMPLIES(a_pop_data, clk, arst_n, cmd.pop, sts.not_empty)
	// A pending result is never overwritten.
	`KCF_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.load_out,
		!out_ch.valid || out_ch.ready)

endmodule
